[hdl/spll_pkg.sv]
// ----------------------------------------------------------------------------
// Slot pool linked list package
// Shared widths, link encoding, request kinds and result status codes.
// ----------------------------------------------------------------------------
package spll_pkg;

  // The slot field is four bits wide, so the pool holds exactly sixteen slots.
  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned LINK_W  = SLOT_W + 1;
  localparam int unsigned COUNT_W = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [COUNT_W-1:0] count_t;

  // A link equal to the slot count marks the end of a chain.
  localparam link_t LINK_NONE = link_t'(SLOTS);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FIRST   = 2'd2,
    KIND_NEXT    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2,
    STAT_END      = 2'd3
  } status_e;

endpackage

[hdl/slot_pool_linked_list_top.sv]
// ----------------------------------------------------------------------------
// Slot pool with free chain and doubly linked active list
// Allocates, releases and walks slots of a sixteen-entry pool, one request
// per transfer, and reports a status, a slot and the count in use.
// ----------------------------------------------------------------------------
// A request's result is registered and presented in the cycle after its transfer.
// Throughput: one request per cycle; all link updates for a request are written
// to the flip-flop link tables in the same cycle as the result register.
// A stalled result register holds off new requests until it is taken.
// Reset: the free chain runs 0 -> 1 -> ... -> 15, the active list is empty,
// the count in use is zero and no result is pending.
module slot_pool_linked_list_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] slot, [7:4] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] slot_out, [8:4] in_use_count,
                                     // [15:9] zero
  output logic [1:0] m_axis_tuser    // [1:0] status
);
  import spll_pkg::*;

  link_t            next_q [SLOTS];
  link_t            next_d [SLOTS];
  link_t            prev_q [SLOTS];
  link_t            prev_d [SLOTS];
  logic [SLOTS-1:0] busy_q, busy_d;
  link_t            free_head_q, free_head_d;
  link_t            list_head_q, list_head_d;
  count_t           used_q, used_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  slot_t            found_q, found_d;
  count_t           count_q;

  logic   accept;
  kind_e  kind;
  slot_t  req_slot;
  slot_t  fh_slot;
  slot_t  lh_slot;
  link_t  rel_prev;
  link_t  rel_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_e'(s_axis_tuser);
  assign req_slot      = s_axis_tdata[SLOT_W-1:0];
  assign fh_slot       = free_head_q[SLOT_W-1:0];
  assign lh_slot       = list_head_q[SLOT_W-1:0];
  assign rel_prev      = prev_q[req_slot];
  assign rel_next      = next_q[req_slot];

  always_comb begin
    next_d      = next_q;
    prev_d      = prev_q;
    busy_d      = busy_q;
    free_head_d = free_head_q;
    list_head_d = list_head_q;
    used_d      = used_q;
    status_d    = STAT_OK;
    found_d     = '0;
    case (kind)
      KIND_ALLOC: begin
        if (free_head_q[SLOT_W]) begin
          status_d = STAT_FULL;
        end else begin
          // Pop the free head and push it at the front of the active list.
          free_head_d      = next_q[fh_slot];
          next_d[fh_slot]  = list_head_q;
          prev_d[fh_slot]  = LINK_NONE;
          if (!list_head_q[SLOT_W]) begin
            prev_d[lh_slot] = free_head_q;
          end
          list_head_d      = free_head_q;
          busy_d[fh_slot]  = 1'b1;
          used_d           = used_q + count_t'(1);
          found_d          = fh_slot;
        end
      end
      KIND_RELEASE: begin
        if (!busy_q[req_slot]) begin
          status_d = STAT_NOT_USED;
        end else begin
          if (!rel_prev[SLOT_W]) begin
            next_d[rel_prev[SLOT_W-1:0]] = rel_next;
          end else begin
            list_head_d = rel_next;
          end
          if (!rel_next[SLOT_W]) begin
            prev_d[rel_next[SLOT_W-1:0]] = rel_prev;
          end
          next_d[req_slot] = free_head_q;
          prev_d[req_slot] = LINK_NONE;
          free_head_d      = {1'b0, req_slot};
          busy_d[req_slot] = 1'b0;
          used_d           = used_q - count_t'(1);
        end
      end
      KIND_FIRST: begin
        if (list_head_q[SLOT_W]) begin
          status_d = STAT_END;
        end else begin
          found_d = lh_slot;
        end
      end
      KIND_NEXT: begin
        if (!busy_q[req_slot]) begin
          status_d = STAT_NOT_USED;
        end else if (rel_next[SLOT_W]) begin
          status_d = STAT_END;
        end else begin
          found_d = rel_next[SLOT_W-1:0];
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        next_q[i] <= link_t'(i + 1);
        prev_q[i] <= LINK_NONE;
      end
      busy_q      <= '0;
      free_head_q <= '0;
      list_head_q <= LINK_NONE;
      used_q      <= '0;
    end else if (accept) begin
      next_q      <= next_d;
      prev_q      <= prev_d;
      busy_q      <= busy_d;
      free_head_q <= free_head_d;
      list_head_q <= list_head_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      count_q  <= used_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, count_q, found_q};

  // The count in use always matches the number of busy slots.
  a_count_matches_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == int'(used_q))
    else $error("in-use count differs from busy slot total");

  // The free chain is empty exactly when every slot is in use.
  a_free_empty_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == LINK_NONE) == (used_q == count_t'(SLOTS)))
    else $error("free chain state disagrees with in-use count");

  // The active list is empty exactly when no slot is in use.
  a_list_empty_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_head_q == LINK_NONE) == (used_q == '0))
    else $error("active list state disagrees with in-use count");

  // A listed head slot is always marked busy.
  a_head_is_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !list_head_q[SLOT_W] |-> busy_q[lh_slot])
    else $error("active list head is not marked busy");

endmodule
